// ===== hdl/prank_pkg.sv =====
// ----------------------------------------------------------------------------
// prank_pkg
// Shared types and constants for the permutation ranking pipeline.
// ----------------------------------------------------------------------------
package prank_pkg;

   localparam int MAX_LEN    = 12;                   // longest permutation ranked
   localparam int NUM_ELEMS  = 12;                   // element fields per beat
   localparam int ELEM_W     = 4;
   localparam int LEN_W      = 4;
   localparam int RANK_W     = 29;
   localparam int POS_W      = $clog2(NUM_ELEMS);
   localparam int TREE_N     = 2 ** POS_W;           // leaves of the max tree
   localparam int NUM_STAGES = MAX_LEN - 1;
   localparam int REQ_W      = ((NUM_ELEMS * ELEM_W + 7) / 8) * 8;
   localparam int RSP_W      = ((RANK_W + 7) / 8) * 8;
   localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(MAX_LEN);

   typedef logic [ELEM_W-1:0] elem_type;
   typedef logic [POS_W-1:0]  pos_type;

   typedef struct packed {
      elem_type [NUM_ELEMS-1:0] elem;
      logic [RANK_W-1:0]        rank;
   } beat_type;

endpackage

// ===== hdl/prank_cell.sv =====
// ----------------------------------------------------------------------------
// prank_cell
// One ranking step: first-largest search over positions 0..limit, digit fold
// into the rank and swap of that element into the limit position.
// ----------------------------------------------------------------------------
module prank_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  prank_pkg::pos_type           limit,
   input  logic [prank_pkg::LEN_W-1:0]  len,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  prank_pkg::beat_type          in_beat,
   output logic                         out_valid,
   input  logic                         out_ready,
   output prank_pkg::beat_type          out_beat
);

   logic                 valid_ff, valid_in;
   prank_pkg::beat_type  beat_ff, beat_in;
   logic                 active;
   logic                 load;
   prank_pkg::elem_type  tree_val [0:prank_pkg::POS_W][0:prank_pkg::TREE_N-1];
   prank_pkg::pos_type   tree_pos [0:prank_pkg::POS_W][0:prank_pkg::TREE_N-1];
   prank_pkg::pos_type   best_pos;
   logic [prank_pkg::RANK_W+prank_pkg::LEN_W:0] product;

   // stage only counts when its limit lies inside the configured length
   assign active   = {1'b0, limit} < {1'b0, len};
   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;

   // max tree, ties go to the left (lower position)
   always_comb begin
      for (int l = 0; l <= prank_pkg::POS_W; l++) begin
         for (int j = 0; j < prank_pkg::TREE_N; j++) begin
            tree_val[l][j] = '0;
            tree_pos[l][j] = '0;
         end
      end
      for (int i = 0; i < prank_pkg::TREE_N; i++) begin
         tree_pos[0][i] = prank_pkg::POS_W'(i);
         if (i < prank_pkg::NUM_ELEMS) begin
            if (prank_pkg::POS_W'(i) <= limit) begin
               tree_val[0][i] = in_beat.elem[i];
            end
         end
      end
      for (int l = 0; l < prank_pkg::POS_W; l++) begin
         for (int j = 0; j < (prank_pkg::TREE_N >> (l + 1)); j++) begin
            if (tree_val[l][2*j+1] > tree_val[l][2*j]) begin
               tree_val[l+1][j] = tree_val[l][2*j+1];
               tree_pos[l+1][j] = tree_pos[l][2*j+1];
            end else begin
               tree_val[l+1][j] = tree_val[l][2*j];
               tree_pos[l+1][j] = tree_pos[l][2*j];
            end
         end
      end
   end

   assign best_pos = tree_pos[prank_pkg::POS_W][0];
   assign product  = in_beat.rank * ({1'b0, limit} + (prank_pkg::POS_W+1)'(1));

   always_comb begin
      beat_in = in_beat;
      if (active) begin
         beat_in.rank = product[prank_pkg::RANK_W-1:0]
                      + prank_pkg::RANK_W'(best_pos);
         beat_in.elem[limit]    = in_beat.elem[best_pos];
         beat_in.elem[best_pos] = in_beat.elem[limit];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         beat_ff <= beat_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_beat  = beat_ff;

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !out_ready |=> valid_ff && $stable(beat_ff))
      else $error("prank_cell: held beat changed during stall");

   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      in_valid && active |-> best_pos <= limit)
      else $error("prank_cell: selected position beyond limit");

   a_idle_pass: assert property (@(posedge clock) disable iff (reset)
      load && !active |=> beat_ff == $past(in_beat))
      else $error("prank_cell: inactive stage altered the beat");

endmodule

// ===== hdl/permutation_rank.sv =====
// ----------------------------------------------------------------------------
// permutation_rank
// Ranks a permutation of up to twelve 4-bit elements in the factorial base.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one permutation per beat, elem_0 in the low nibble of
//   req_tdata. rsp_* returns one beat per request with the rank in the low
//   29 bits of rsp_tdata. csr_* writes perm_length (values above 12 act as
//   12, values 0 and 1 give rank 0); write it only while the block is idle.
//   csr_ready is always high.
// Timing:
//   A row of 11 cells, one per limit from 11 down to 1, each with its own
//   output register; a beat passes through all 11 registers before it shows
//   on rsp_tdata. One beat is accepted every cycle unless the output stalls.
// Reset:
//   Synchronous; clears all cell valids and sets perm_length to 12.
// Stall:
//   When rsp_tready is low, beats pile up in the cells; bubbles are squeezed
//   out, so req_tready drops only when every cell holds a beat.
// ----------------------------------------------------------------------------
module permutation_rank (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // elem_0 [3:0], elem_1 [7:4], ... elem_11 [47:44]
   input  logic [prank_pkg::REQ_W-1:0]  req_tdata,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // rank [28:0], zero [31:29]
   output logic [prank_pkg::RSP_W-1:0]  rsp_tdata,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [prank_pkg::LEN_W-1:0]  csr_data
);

   logic [prank_pkg::LEN_W-1:0] len_ff, len_in;
   logic [prank_pkg::LEN_W-1:0] len_eff;
   logic                        chain_valid [0:prank_pkg::NUM_STAGES];
   logic                        chain_ready [0:prank_pkg::NUM_STAGES];
   prank_pkg::beat_type         chain_beat  [0:prank_pkg::NUM_STAGES];

   assign csr_ready = 1'b1;

   always_comb begin
      len_in = len_ff;
      if (csr_valid && csr_ready) begin
         len_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= prank_pkg::LEN_RESET;
      end else begin
         len_ff <= len_in;
      end
   end

   assign len_eff = (len_ff > prank_pkg::LEN_W'(prank_pkg::MAX_LEN))
                  ? prank_pkg::LEN_W'(prank_pkg::MAX_LEN) : len_ff;

   always_comb begin
      chain_beat[0].rank = '0;
      for (int i = 0; i < prank_pkg::NUM_ELEMS; i++) begin
         chain_beat[0].elem[i] = req_tdata[i*prank_pkg::ELEM_W +: prank_pkg::ELEM_W];
      end
   end

   assign chain_valid[0] = req_tvalid;
   assign req_tready     = chain_ready[0];

   for (genvar k = 0; k < prank_pkg::NUM_STAGES; k++) begin : g_cell
      prank_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .limit     (prank_pkg::POS_W'(prank_pkg::MAX_LEN - 1 - k)),
         .len       (len_eff),
         .in_valid  (chain_valid[k]),
         .in_ready  (chain_ready[k]),
         .in_beat   (chain_beat[k]),
         .out_valid (chain_valid[k+1]),
         .out_ready (chain_ready[k+1]),
         .out_beat  (chain_beat[k+1])
      );
   end

   assign chain_ready[prank_pkg::NUM_STAGES] = rsp_tready;
   assign rsp_tvalid = chain_valid[prank_pkg::NUM_STAGES];
   assign rsp_tdata  = prank_pkg::RSP_W'(chain_beat[prank_pkg::NUM_STAGES].rank);

endmodule
